### hdl/u8vd_pkg.sv
// Shared types and constants for the UTF-8 validating decoder.
package u8vd_pkg;

  // Field widths of the byte and code point words.
  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned LenW  = 3;
  localparam int unsigned CntW  = 3;
  localparam int unsigned WinN  = 4;

  // Lead byte class boundaries.
  localparam logic [7:0] Lead2Min  = 8'hC0;
  localparam logic [7:0] Lead3Min  = 8'hE0;
  localparam logic [7:0] Lead4Min  = 8'hF0;
  localparam logic [7:0] LeadBadLo = 8'hF8;
  localparam logic [1:0] ContTag   = 2'b10;

  // Range limits for overlong, surrogate and out of range checks.
  localparam logic [CpW-1:0] Max1Byte  = 21'h00007F;
  localparam logic [CpW-1:0] Max2Byte  = 21'h0007FF;
  localparam logic [CpW-1:0] Max3Byte  = 21'h00FFFF;
  localparam logic [CpW-1:0] CpLimit   = 21'h110000;
  localparam logic [CpW-1:0] SurrLo    = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi    = 21'h00DFFF;

  // Sequence lengths.
  localparam logic [LenW-1:0] LenNone = 3'd0;
  localparam logic [LenW-1:0] LenOne  = 3'd1;
  localparam logic [LenW-1:0] LenTwo  = 3'd2;
  localparam logic [LenW-1:0] LenThr  = 3'd3;
  localparam logic [LenW-1:0] LenFour = 3'd4;

  typedef logic [ByteW-1:0] byte_t;
  typedef byte_t [WinN-1:0] win_t;

  // Outcome of decoding the front of the byte window.
  typedef struct packed {
    logic            emit;
    logic [CpW-1:0]  code_point;
    logic            is_error;
    logic [LenW-1:0] seq_length;
    logic [CntW-1:0] consume;
  } front_res_t;

endpackage

### hdl/u8vd_if.sv
// Valid/ready channel interfaces for the byte input and the code point output.
interface u8vd_in_if import u8vd_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ByteW-1:0]    in_byte;
  logic                flush;

  modport source (output valid, output in_byte, output flush, input ready);
  modport sink   (input valid, input in_byte, input flush, output ready);
endinterface

interface u8vd_out_if import u8vd_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CpW-1:0]      code_point;
  logic                is_error;
  logic [LenW-1:0]     seq_length;
  logic                last_of_run;

  modport source (output valid, output code_point, output is_error, output seq_length,
                  output last_of_run, input ready);
  modport sink   (input valid, input code_point, input is_error, input seq_length,
                  input last_of_run, output ready);
endinterface

### hdl/u8vd_front.sv
// Decoder for the sequence at the front of a window of up to four bytes.
module u8vd_front import u8vd_pkg::*; (
  input  win_t            win_i,
  input  logic [CntW-1:0] cnt_i,
  input  logic            flush_i,
  output front_res_t      res_o
);

  byte_t           lead;
  logic [LenW-1:0] need;
  logic            bad;
  logic            short;
  logic [CpW-1:0]  cp2;
  logic [CpW-1:0]  cp3;
  logic [CpW-1:0]  cp4;
  logic            ok2;
  logic            ok3;
  logic            ok4;

  assign lead = win_i[0];

  // Candidate code points for each sequence length.
  assign cp2 = {10'd0, lead[4:0], win_i[1][5:0]};
  assign cp3 = {5'd0, lead[3:0], win_i[1][5:0], win_i[2][5:0]};
  assign cp4 = {lead[2:0], win_i[1][5:0], win_i[2][5:0], win_i[3][5:0]};

  // Reject overlong forms, surrogates and values beyond the code space.
  assign ok2 = cp2 > Max1Byte;
  assign ok3 = (cp3 > Max2Byte) && ((cp3 < SurrLo) || (cp3 > SurrHi));
  assign ok4 = (cp4 > Max3Byte) && (cp4 < CpLimit);

  // Sequence length implied by the lead byte; zero for an invalid lead.
  always_comb begin
    if (lead < Lead2Min || lead >= LeadBadLo) begin
      need = LenNone;
    end else if (lead < Lead3Min) begin
      need = LenTwo;
    end else if (lead < Lead4Min) begin
      need = LenThr;
    end else begin
      need = LenFour;
    end
  end

  // Check every continuation byte that is already present.
  always_comb begin
    bad = (need == LenNone);
    for (int i = 1; i < WinN; i++) begin
      if ((LenW'(i) < need) && (CntW'(i) < cnt_i) && (win_i[i][7:6] != ContTag)) begin
        bad = 1'b1;
      end
    end
  end

  assign short = cnt_i < CntW'(need);

  // Pick the outcome: nothing, a valid code point or an error word.
  always_comb begin
    res_o = '0;
    if (cnt_i == '0) begin
      res_o.emit = 1'b0;
    end else if (!lead[7]) begin
      res_o.emit       = 1'b1;
      res_o.code_point = {13'd0, lead};
      res_o.seq_length = LenOne;
      res_o.consume    = CntW'(1);
    end else if (!bad && short && !flush_i) begin
      res_o.emit = 1'b0;
    end else begin
      res_o.emit       = 1'b1;
      res_o.is_error   = 1'b1;
      res_o.code_point = {13'd0, lead};
      res_o.seq_length = LenNone;
      res_o.consume    = CntW'(1);
      if (!bad && !short) begin
        case (need)
          LenTwo: begin
            if (ok2) begin
              res_o.is_error   = 1'b0;
              res_o.code_point = cp2;
              res_o.seq_length = LenTwo;
              res_o.consume    = CntW'(LenTwo);
            end
          end
          LenThr: begin
            if (ok3) begin
              res_o.is_error   = 1'b0;
              res_o.code_point = cp3;
              res_o.seq_length = LenThr;
              res_o.consume    = CntW'(LenThr);
            end
          end
          LenFour: begin
            if (ok4) begin
              res_o.is_error   = 1'b0;
              res_o.code_point = cp4;
              res_o.seq_length = LenFour;
              res_o.consume    = CntW'(LenFour);
            end
          end
          default: begin
            res_o.is_error = 1'b1;
          end
        endcase
      end
    end
  end

endmodule

### hdl/utf8_validating_decoder.sv
// A result word is decoded from the window register and loaded into the output register.
// Throughput: one byte per cycle while each byte gives at most one result and the output
// register is free or being read; a byte that releases several results holds intake until
// the last is loaded, as the front decoder drains one result per cycle while the output frees.
// Reset clears the held byte count, the flush flag, the busy flag and the output valid;
// held bytes are not cleared and are never read until written.
module utf8_validating_decoder import u8vd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  u8vd_in_if.sink    in_i,
  u8vd_out_if.source out_o
);

  win_t            win_q, win_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            fl_q, fl_d;
  logic            busy_q, busy_d;
  logic            oval_q, oval_d;
  front_res_t      res_q;
  logic            last_q;

  front_res_t      cur;
  front_res_t      nxt;
  win_t            sh_win;
  logic [CntW-1:0] sh_cnt;
  win_t            rem_win;
  logic [CntW-1:0] rem_cnt;
  logic            out_load;
  logic            done;
  logic            accept;

  // Decode the front of the current window.
  u8vd_front u_cur (
    .win_i   (win_q),
    .cnt_i   (cnt_q),
    .flush_i (fl_q),
    .res_o   (cur)
  );

  // Window left after the current result is taken.
  always_comb begin
    sh_win = '0;
    case (cur.consume)
      CntW'(1): sh_win = {8'd0, win_q[3], win_q[2], win_q[1]};
      CntW'(2): sh_win = {16'd0, win_q[3], win_q[2]};
      CntW'(3): sh_win = {24'd0, win_q[3]};
      default:  sh_win = '0;
    endcase
  end
  assign sh_cnt = cnt_q - cur.consume;

  // Look ahead: does the remaining window give another result for this word?
  u8vd_front u_nxt (
    .win_i   (sh_win),
    .cnt_i   (sh_cnt),
    .flush_i (fl_q),
    .res_o   (nxt)
  );

  // Handshake and sequencing control.
  assign out_load = busy_q && cur.emit && (!oval_q || out_o.ready);
  assign done     = !busy_q || !cur.emit || (out_load && !nxt.emit);
  assign accept   = in_i.valid && done;
  assign in_i.ready = done;

  // Next window: remaining bytes with a newly accepted byte appended.
  always_comb begin
    rem_win = out_load ? sh_win : win_q;
    rem_cnt = out_load ? sh_cnt : cnt_q;
    win_d   = rem_win;
    cnt_d   = rem_cnt;
    fl_d    = fl_q;
    if (accept) begin
      win_d[rem_cnt[1:0]] = in_i.in_byte;
      cnt_d               = rem_cnt + CntW'(1);
      fl_d                = in_i.flush;
    end
    busy_d = accept ? 1'b1 : (done ? 1'b0 : busy_q);
    oval_d = out_load || (oval_q && !out_o.ready);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      fl_q   <= 1'b0;
      busy_q <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      fl_q   <= fl_d;
      busy_q <= busy_d;
      oval_q <= oval_d;
    end
  end

  // Window bytes and result word.
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (out_load) begin
      res_q  <= cur;
      last_q <= !nxt.emit;
    end
  end

  assign out_o.valid       = oval_q;
  assign out_o.code_point  = res_q.code_point;
  assign out_o.is_error    = res_q.is_error;
  assign out_o.seq_length  = res_q.seq_length;
  assign out_o.last_of_run = last_q;

endmodule

### dv/testbench.sv
// Self-checking testbench for the UTF-8 validating decoder, driven by directed and random bytes.
`timescale 1ns / 100ps
module testbench;
  import u8vd_pkg::*;

  localparam int unsigned HalfPeriod  = 5;
  localparam int unsigned RandomBytes = 300;
  localparam int unsigned QuietTail   = 40;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned TailCycles  = 20;
  localparam byte_t       ContMin     = 8'h80;

  // One pending input word: a byte, its flush flag and whether the sender must drain first.
  typedef struct {
    byte_t b;
    logic  fl;
    bit    drain_first;
  } stim_t;

  // One decoded result word as it should leave the block.
  typedef struct {
    logic [CpW-1:0]  code_point;
    logic            is_error;
    logic [LenW-1:0] seq_length;
    logic            last_of_run;
  } cp_word_t;

  // Shapes of byte sequences that the random part produces.
  typedef enum int unsigned {
    SeqValid, SeqBadCont, SeqOverlong, SeqSurrogate, SeqAbove,
    SeqTruncated, SeqStray, SeqHighLead, SeqNoise
  } seq_kind_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Testbench-side drivers, known from time zero.
  logic  byte_valid = 1'b0;
  byte_t byte_data  = '0;
  logic  byte_flush = 1'b0;
  logic  word_ready = 1'b0;

  u8vd_in_if  in_if ();
  u8vd_out_if out_if ();

  assign in_if.valid   = byte_valid;
  assign in_if.in_byte = byte_data;
  assign in_if.flush   = byte_flush;
  assign out_if.ready  = word_ready;

  utf8_validating_decoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  stim_t       byte_q[$];
  cp_word_t    cp_expect_q[$];
  byte_t       held_b[3];
  int unsigned held_n = 0;
  byte_t       seq_b[4];
  int unsigned seq_n;
  stim_t       stim_cur;
  cp_word_t    exp_w;
  logic        in_took      = 1'b0;
  int unsigned src_gap      = 0;
  int unsigned snk_gap      = 0;
  bit          no_idle      = 1'b0;
  bit          hold_next    = 1'b0;
  int unsigned stall_cycles = 0;
  int unsigned n_err        = 0;

  always #HalfPeriod clk_i = ~clk_i;

  // Predicts the code points released by one accepted byte and queues them.
  function automatic void decode_byte(input byte_t b_new, input logic fl);
    byte_t          win [WinN];
    cp_word_t       run_q[$];
    cp_word_t       w;
    int unsigned    n, pos, need, avail, k;
    byte_t          lead;
    logic [CpW-1:0] cp;
    logic           bad, ok, halt;
    n = held_n;
    for (k = 0; k < n; k++) win[k] = held_b[k];
    win[n] = b_new;
    n++;
    pos  = 0;
    halt = 1'b0;
    while (pos < n && run_q.size() < WinN && !halt) begin
      lead  = win[pos];
      avail = n - pos;
      bad   = 1'b0;
      ok    = 1'b0;
      cp    = '0;
      // Classify the lead by how many bytes it announces; zero means it cannot lead.
      if (lead < ContMin) need = 1;
      else if (lead < Lead2Min || lead >= LeadBadLo) need = 0;
      else if (lead < Lead3Min) need = 2;
      else if (lead < Lead4Min) need = 3;
      else need = 4;
      if (need == 0) bad = 1'b1;
      // Every continuation byte present so far must carry the continuation tag.
      for (k = 1; k < need && k < avail; k++) begin
        if (win[pos+k][7:6] != ContTag) bad = 1'b1;
      end
      // An incomplete sequence waits for more bytes unless the stream is being flushed.
      if (!bad && avail < need) begin
        if (fl) bad = 1'b1;
        else halt = 1'b1;
      end
      if (!bad && !halt) begin
        case (need)
          1: begin
            cp = CpW'(lead);
            ok = 1'b1;
          end
          2: begin
            cp = CpW'({lead[4:0], win[pos+1][5:0]});
            ok = cp > Max1Byte;
          end
          3: begin
            cp = CpW'({lead[3:0], win[pos+1][5:0], win[pos+2][5:0]});
            ok = cp > Max2Byte && (cp < SurrLo || cp > SurrHi);
          end
          default: begin
            cp = {lead[2:0], win[pos+1][5:0], win[pos+2][5:0], win[pos+3][5:0]};
            ok = cp > Max3Byte && cp < CpLimit;
          end
        endcase
      end
      if (!halt) begin
        w.last_of_run = 1'b0;
        if (ok) begin
          w.code_point = cp;
          w.is_error   = 1'b0;
          w.seq_length = LenW'(need);
          pos          = pos + need;
        end else begin
          // Only the lead is consumed; the bytes after it are decoded again.
          w.code_point = CpW'(lead);
          w.is_error   = 1'b1;
          w.seq_length = LenNone;
          pos          = pos + 1;
        end
        run_q.push_back(w);
      end
    end
    held_n = n - pos;
    for (k = 0; k < held_n; k++) held_b[k] = win[pos+k];
    if (run_q.size() != 0) run_q[run_q.size()-1].last_of_run = 1'b1;
    foreach (run_q[i]) cp_expect_q.push_back(run_q[i]);
  endfunction

  task automatic add_byte(input byte_t b, input logic fl);
    stim_t s;
    s.b           = b;
    s.fl          = fl;
    s.drain_first = hold_next;
    hold_next     = 1'b0;
    byte_q.push_back(s);
  endtask

  // Builds a well-formed encoding of a random code point of the given length.
  task automatic build_valid(input int unsigned len);
    logic [CpW-1:0] cp;
    case (len)
      1: begin
        cp       = CpW'($urandom_range(0, 'h7F));
        seq_b[0] = cp[7:0];
      end
      2: begin
        cp       = CpW'($urandom_range('h80, 'h7FF));
        seq_b[0] = {Lead2Min[7:5], cp[10:6]};
        seq_b[1] = {ContTag, cp[5:0]};
      end
      3: begin
        cp = CpW'($urandom_range('h800, 'hFFFF));
        // Move surrogates down out of the reserved range.
        if (cp >= SurrLo && cp <= SurrHi) cp = cp - CpW'('h1000);
        seq_b[0] = {Lead3Min[7:4], cp[15:12]};
        seq_b[1] = {ContTag, cp[11:6]};
        seq_b[2] = {ContTag, cp[5:0]};
      end
      default: begin
        cp       = CpW'($urandom_range('h10000, 'h10FFFF));
        seq_b[0] = {Lead4Min[7:3], cp[20:18]};
        seq_b[1] = {ContTag, cp[17:12]};
        seq_b[2] = {ContTag, cp[11:6]};
        seq_b[3] = {ContTag, cp[5:0]};
      end
    endcase
    seq_n = len;
  endtask

  // Appends one random sequence, mostly well formed, the rest broken or noise.
  task automatic add_random_seq();
    int unsigned r, pick, k;
    seq_kind_e   kind;
    logic        fl;
    byte_t       nb;
    r  = $urandom_range(0, 99);
    fl = ($urandom_range(0, 9) == 0);
    if (r < 60) kind = SeqValid;
    else if (r < 66) kind = SeqBadCont;
    else if (r < 71) kind = SeqOverlong;
    else if (r < 75) kind = SeqSurrogate;
    else if (r < 79) kind = SeqAbove;
    else if (r < 87) kind = SeqTruncated;
    else if (r < 91) kind = SeqStray;
    else if (r < 94) kind = SeqHighLead;
    else kind = SeqNoise;
    for (k = 1; k < 4; k++) seq_b[k] = {ContTag, 6'($urandom_range(0, 63))};
    case (kind)
      SeqValid: build_valid($urandom_range(1, 4));
      SeqBadCont: begin
        build_valid($urandom_range(2, 4));
        pick = $urandom_range(1, seq_n - 1);
        nb   = 8'($urandom_range(0, 255));
        if (nb[7:6] == ContTag) nb[6] = 1'b1;
        seq_b[pick] = nb;
      end
      SeqOverlong: begin
        seq_n = $urandom_range(2, 4);
        case (seq_n)
          2: seq_b[0] = 8'($urandom_range('hC0, 'hC1));
          3: begin
            seq_b[0] = 8'hE0;
            seq_b[1] = 8'($urandom_range('h80, 'h9F));
          end
          default: begin
            seq_b[0] = 8'hF0;
            seq_b[1] = 8'($urandom_range('h80, 'h8F));
          end
        endcase
      end
      SeqSurrogate: begin
        seq_n    = 3;
        seq_b[0] = 8'hED;
        seq_b[1] = 8'($urandom_range('hA0, 'hBF));
      end
      SeqAbove: begin
        seq_n    = 4;
        seq_b[0] = 8'($urandom_range('hF4, 'hF7));
        if (seq_b[0] == 8'hF4) seq_b[1] = 8'($urandom_range('h90, 'hBF));
      end
      SeqTruncated: begin
        build_valid($urandom_range(2, 4));
        seq_n = $urandom_range(1, seq_n - 1);
        fl    = ($urandom_range(0, 1) == 0);
      end
      SeqStray: begin
        seq_n    = 1;
        seq_b[0] = 8'($urandom_range('h80, 'hBF));
      end
      SeqHighLead: begin
        seq_n    = 1;
        seq_b[0] = 8'($urandom_range('hF8, 'hFF));
      end
      default: begin
        seq_n    = 1;
        seq_b[0] = 8'($urandom_range(0, 255));
        fl       = ($urandom_range(0, 3) == 0);
      end
    endcase
    for (k = 0; k < seq_n; k++) add_byte(seq_b[k], fl && (k == seq_n - 1));
  endtask

  // Byte driver: presents the next pending word after the previous one was taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      no_idle <= (byte_q.size() < QuietTail) || ((byte_q.size() / 32) % 3 == 1);
      if (!byte_valid || in_took) begin
        if (src_gap != 0) begin
          byte_valid <= 1'b0;
          src_gap    <= src_gap - 1;
        end else if (byte_q.size() != 0 &&
                     !(byte_q[0].drain_first && cp_expect_q.size() != 0)) begin
          stim_cur   = byte_q.pop_front();
          byte_valid <= 1'b1;
          byte_data  <= stim_cur.b;
          byte_flush <= stim_cur.fl;
          if (!no_idle && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 14);
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // Result sink: ready except for random stall bursts.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (snk_gap != 0) begin
        word_ready <= 1'b0;
        snk_gap    <= snk_gap - 1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        word_ready <= 1'b0;
        snk_gap    <= $urandom_range(0, 13);
      end else begin
        word_ready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on each accepted byte and checks each accepted result word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_took  <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) decode_byte(in_if.in_byte, in_if.flush);
      if (out_if.valid && out_if.ready) begin
        if (cp_expect_q.size() == 0) begin
          $error("unexpected result word: code_point %0h", out_if.code_point);
          n_err = n_err + 1;
        end else begin
          exp_w = cp_expect_q.pop_front();
          if (out_if.code_point !== exp_w.code_point) begin
            $error("code_point mismatch: expected %0h, got %0h",
                   exp_w.code_point, out_if.code_point);
            n_err = n_err + 1;
          end
          if (out_if.is_error !== exp_w.is_error) begin
            $error("is_error mismatch: expected %0d, got %0d", exp_w.is_error, out_if.is_error);
            n_err = n_err + 1;
          end
          if (out_if.seq_length !== exp_w.seq_length) begin
            $error("seq_length mismatch: expected %0d, got %0d",
                   exp_w.seq_length, out_if.seq_length);
            n_err = n_err + 1;
          end
          if (out_if.last_of_run !== exp_w.last_of_run) begin
            $error("last_of_run mismatch: expected %0d, got %0d",
                   exp_w.last_of_run, out_if.last_of_run);
            n_err = n_err + 1;
          end
        end
      end
      // Watchdog: count cycles in which no word moves on either side.
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned target;
    bit          mid_done;
    // Directed part: field extremes, longest and shortest forms, and each way to fail.
    add_byte(8'h00, 1'b0);
    add_byte(8'hC2, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'hEF, 1'b0); add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
    add_byte(8'hF4, 1'b0); add_byte(8'h8F, 1'b0); add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
    // Stray continuation byte, then a lead that can never start a sequence.
    add_byte(8'h80, 1'b0);
    add_byte(8'hFF, 1'b0);
    // Second byte is not a continuation.
    add_byte(8'hC3, 1'b0); add_byte(8'h41, 1'b0);
    // Overlong two-byte form.
    add_byte(8'hC0, 1'b0); add_byte(8'hAF, 1'b0);
    // Surrogate.
    add_byte(8'hED, 1'b0); add_byte(8'hA0, 1'b0); add_byte(8'h80, 1'b0);
    // Just above the highest code point.
    add_byte(8'hF4, 1'b0); add_byte(8'h90, 1'b0); add_byte(8'h80, 1'b0); add_byte(8'h80, 1'b0);
    // Missing continuation bytes when the stream is flushed.
    add_byte(8'hF0, 1'b0); add_byte(8'h9F, 1'b1);

    // Random part; the first random word and one halfway wait for all results to drain.
    target    = byte_q.size() + RandomBytes;
    mid_done  = 1'b0;
    hold_next = 1'b1;
    while (byte_q.size() < target) begin
      if (!mid_done && byte_q.size() >= target - RandomBytes / 2) begin
        hold_next = 1'b1;
        mid_done  = 1'b1;
      end
      add_random_seq();
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while ((byte_q.size() != 0 || byte_valid || cp_expect_q.size() != 0) &&
           stall_cycles < StallLimit)
      @(posedge clk_i);
    if (stall_cycles < StallLimit) repeat (TailCycles) @(posedge clk_i);

    if (stall_cycles >= StallLimit) begin
      $display("Verification failed");
    end else if (n_err == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
